// ===== sv/fbg_pkg.sv =====
// Shared types and constants of the forbidden tuple grounder.
package fbg_pkg;

	localparam int NUM_PARAMS      = 8;
	localparam int MAX_CONSTRAINTS = 32;
	localparam int VAL_W           = 5;
	localparam int POS_W           = $clog2(NUM_PARAMS);
	localparam int ADDR_W          = $clog2(MAX_CONSTRAINTS);
	localparam int CNT_W           = $clog2(MAX_CONSTRAINTS + 1);
	localparam int MAXV_W          = 32;
	localparam int NUM_REG_W       = 6;
	localparam int NIB_W           = 4;

	localparam logic [VAL_W-1:0] UNBOUND = 5'h1F;

	typedef logic [VAL_W-1:0] val_t;
	typedef val_t [NUM_PARAMS-1:0] case_t;

	typedef enum logic [1:0] {
		MODE_WRITE  = 2'd0,
		MODE_CHECK  = 2'd1,
		MODE_GROUND = 2'd2
	} mode_t;

	typedef enum logic {
		REG_MAX_VALUES      = 1'b0,
		REG_NUM_CONSTRAINTS = 1'b1
	} reg_idx_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_TRY,
		S_DONE
	} state_t;

	typedef struct packed {
		logic              wr_en;
		logic              rd_en;
		logic [ADDR_W-1:0] addr;
		case_t             wdata;
	} mem_req_t;

	typedef struct packed {
		logic  flag;
		case_t vals;
	} res_t;

endpackage

// ===== sv/fbg_table.sv =====
// Constraint table memory: one write or one registered read per cycle.
module fbg_table (
	input  logic             clk,
	input  fbg_pkg::mem_req_t req,
	output fbg_pkg::case_t   rd_data
);
	import fbg_pkg::*;

	case_t mem_q [MAX_CONSTRAINTS];
	case_t rd_data_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem_q[req.addr] <= req.wdata;
		end
		if (req.rd_en) begin
			rd_data_q <= mem_q[req.addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== sv/fbg_match.sv =====
// Compare unit: does one table entry forbid the test case.
module fbg_match (
	input  fbg_pkg::case_t entry,
	input  fbg_pkg::case_t tcase,
	output logic           hit
);
	import fbg_pkg::*;

	always_comb begin
		hit = 1'b1;
		for (int p = 0; p < NUM_PARAMS; p++) begin
			// don't-care skips; an unbound case value can only equal an unbound entry value
			if (entry[p] != UNBOUND && entry[p] != tcase[p]) begin
				hit = 1'b0;
			end
		end
	end

endmodule

// ===== sv/fbg_ctrl.sv =====
// Sequencer: table scan and depth-first ground search around the shared compare unit.
module fbg_ctrl (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	input  logic [1:0]                          in_mode,
	input  logic [fbg_pkg::ADDR_W-1:0]          in_slot,
	input  fbg_pkg::case_t                      in_case,
	input  logic [fbg_pkg::MAXV_W-1:0]          max_values,
	input  logic [fbg_pkg::CNT_W-1:0]           num_used,
	input  fbg_pkg::case_t                      rd_data,
	input  logic                                out_free,
	output logic                                in_ready,
	output fbg_pkg::mem_req_t                   mem_req,
	output logic                                res_valid,
	output fbg_pkg::res_t                       res
);
	import fbg_pkg::*;

	state_t                  state_q, state_d;
	logic [1:0]              mode_q;
	case_t                   in_q;
	case_t                   work_q;
	logic [NUM_PARAMS-1:0]   ub_q;
	logic [POS_W-1:0]        pos_q;
	logic [CNT_W-1:0]        idx_q;
	logic                    pend_q;
	logic                    flag_q;
	logic                    use_work_q;

	logic                    match_hit;
	logic                    hit_s;
	logic                    scan_end;
	logic [NIB_W-1:0]        mx;
	val_t                    cand;
	logic                    over;
	logic [NUM_PARAMS-1:0]   ub_in;
	logic                    first_ok, nxt_ok, prv_ok;
	logic [POS_W-1:0]        first_pos, nxt_pos, prv_pos;
	logic                    accept;

	fbg_match u_match (
		.entry (rd_data),
		.tcase (work_q),
		.hit   (match_hit)
	);

	assign accept   = (state_q == S_IDLE) && in_valid;
	assign hit_s    = pend_q && match_hit;
	assign scan_end = hit_s || (idx_q >= num_used);
	assign mx       = max_values[{pos_q, 2'b00} +: NIB_W];
	assign cand     = (work_q[pos_q] == UNBOUND) ? '0 : work_q[pos_q] + 5'd1;
	assign over     = cand > {1'b0, mx};

	// position search over the unbound mask
	always_comb begin
		first_ok  = 1'b0;
		first_pos = '0;
		nxt_ok    = 1'b0;
		nxt_pos   = '0;
		prv_ok    = 1'b0;
		prv_pos   = '0;
		for (int p = 0; p < NUM_PARAMS; p++) begin
			ub_in[p] = (in_case[p] == UNBOUND);
		end
		for (int p = NUM_PARAMS - 1; p >= 0; p--) begin
			if (ub_in[p]) begin
				first_ok  = 1'b1;
				first_pos = POS_W'(p);
			end
			if (ub_q[p] && POS_W'(p) > pos_q) begin
				nxt_ok  = 1'b1;
				nxt_pos = POS_W'(p);
			end
		end
		for (int p = 0; p < NUM_PARAMS; p++) begin
			if (ub_q[p] && POS_W'(p) < pos_q) begin
				prv_ok  = 1'b1;
				prv_pos = POS_W'(p);
			end
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					case (in_mode)
						MODE_CHECK:  state_d = S_SCAN;
						MODE_GROUND: state_d = first_ok ? S_TRY : S_DONE;
						default:     state_d = S_DONE;
					endcase
				end
			end
			S_SCAN: begin
				if (scan_end) begin
					if (mode_q == MODE_CHECK) begin
						state_d = S_DONE;
					end else if (hit_s || nxt_ok) begin
						state_d = S_TRY;
					end else begin
						state_d = S_DONE;
					end
				end
			end
			S_TRY: begin
				if (!over) begin
					state_d = S_SCAN;
				end else if (!prv_ok) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_ready      = (state_q == S_IDLE);
		res_valid     = (state_q == S_DONE);
		res.flag      = flag_q;
		res.vals      = use_work_q ? work_q : in_q;
		mem_req.wr_en = accept && (in_mode == MODE_WRITE);
		mem_req.rd_en = (state_q == S_SCAN) && !scan_end;
		mem_req.addr  = mem_req.wr_en ? in_slot : idx_q[ADDR_W-1:0];
		mem_req.wdata = in_case;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pend_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept || state_q == S_TRY) begin
				pend_q <= 1'b0;
			end else if (state_q == S_SCAN) begin
				pend_q <= !scan_end;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					mode_q     <= in_mode;
					in_q       <= in_case;
					work_q     <= in_case;
					ub_q       <= ub_in;
					pos_q      <= first_pos;
					idx_q      <= '0;
					flag_q     <= (in_mode == MODE_GROUND);
					use_work_q <= 1'b0;
				end
			end
			S_SCAN: begin
				if (!scan_end) begin
					idx_q <= idx_q + CNT_W'(1);
				end else if (mode_q == MODE_CHECK) begin
					flag_q <= hit_s;
				end else if (!hit_s) begin
					if (nxt_ok) begin
						pos_q <= nxt_pos;
					end else begin
						flag_q     <= 1'b1;
						use_work_q <= 1'b1;
					end
				end
			end
			S_TRY: begin
				idx_q <= '0;
				if (over) begin
					work_q[pos_q] <= UNBOUND;
					if (prv_ok) begin
						pos_q <= prv_pos;
					end else begin
						flag_q     <= 1'b0;
						use_work_q <= 1'b0;
					end
				end else begin
					work_q[pos_q] <= cand;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== sv/forbidden_tuple_backtracking_grounder.sv =====
// Top level of the forbidden tuple grounder: config registers, table, sequencer, output register.
//
// Usage:
//   s_axis carries one item per transaction: tuser is the mode (write entry,
//   check, ground), tdata the slot and eight 5-bit values (-1 is unbound or
//   don't care). m_axis returns one result per item: tuser is the flag,
//   tdata the eight resulting values.
//   Registers are written on cfg_we: index 0 holds eight 4-bit highest
//   values, index 1 the count of table entries in use. Write them only
//   while no item is in flight.
// Timing:
//   A write item goes from idle straight to its result. A check scans the n
//   entries in use (capped at 32) and stops early when an entry hits:
//   the table memory gives one entry a cycle to the single compare unit.
//   A ground item tries one value at a time, each trial followed by a scan
//   of the entries in use, and backtracks one unbound position at a time, so
//   its length depends on how much the search backtracks.
//   One item is worked on at a time; s_axis_tready is high only while idle.
// Reset and stall:
//   arst_n clears the sequencer and output valid and sets the registers to
//   all-ones maxima and zero entries in use; the table is not cleared.
//   A finished result waits in the output register; the next item is taken
//   meanwhile, and its own result holds in the sequencer until the
//   register frees.
module forbidden_tuple_backtracking_grounder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,  // slot[4:0], value_0..value_7 [44:5], zero pad
	input  logic [1:0]  s_axis_tuser,  // mode[1:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,  // out_0..out_7, 5 bits each from bit 0
	output logic        m_axis_tuser,  // flag
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data
);
	import fbg_pkg::*;

	localparam int CASE_W = NUM_PARAMS * VAL_W;

	logic [MAXV_W-1:0]    max_values_q;
	logic [NUM_REG_W-1:0] num_constraints_q;
	logic [CNT_W-1:0]     num_used;
	mem_req_t             mem_req;
	case_t                rd_data;
	logic                 res_valid;
	res_t                 res;
	logic                 out_valid_q;
	res_t                 out_q;
	logic                 out_free;

	// config writes; counts above the table size use the whole table
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_values_q      <= '1;
			num_constraints_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MAX_VALUES:      max_values_q      <= cfg_data;
				REG_NUM_CONSTRAINTS: num_constraints_q <= cfg_data[NUM_REG_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign num_used = (num_constraints_q > NUM_REG_W'(MAX_CONSTRAINTS)) ?
		CNT_W'(MAX_CONSTRAINTS) : CNT_W'(num_constraints_q);

	fbg_table u_table (
		.clk     (clk),
		.req     (mem_req),
		.rd_data (rd_data)
	);

	fbg_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_mode    (s_axis_tuser),
		.in_slot    (s_axis_tdata[ADDR_W-1:0]),
		.in_case    (s_axis_tdata[ADDR_W +: CASE_W]),
		.max_values (max_values_q),
		.num_used   (num_used),
		.rd_data    (rd_data),
		.out_free   (out_free),
		.in_ready   (s_axis_tready),
		.mem_req    (mem_req),
		.res_valid  (res_valid),
		.res        (res)
	);

	// output register: load when empty or being drained
	assign out_free = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && res_valid) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_q.vals;
	assign m_axis_tuser  = out_q.flag;

endmodule

// ===== sv/fbg_checker.sv =====
// Port checker of the forbidden tuple grounder and its bind.
module fbg_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [39:0] m_axis_tdata,
	input logic        m_axis_tuser
);

	// a stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result dropped while stalled");

	// a stalled result keeps its payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("result payload changed while stalled");

	// the block goes busy after taking an item
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("second item taken before the first finished");

	// no result can appear in the cycle right after an item is taken
	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
		else $error("result came out too early");

endmodule

bind forbidden_tuple_backtracking_grounder fbg_checker u_fbg_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);
